// ----- sv/brc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the box relation classifier.
// No dependencies.
package brc_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int AXES       = 3;
    localparam int CFG_ADDR_W = 3;

    // 0.5 and 15 in fixed point
    localparam int STUCK_RESET = 1 << (FRAC_BITS - 1);
    localparam int FAR_RESET   = 15 << FRAC_BITS;

    typedef enum logic [2:0] {
        REL_INCL  = 3'd0,
        REL_INTER = 3'd1,
        REL_STUCK = 3'd2,
        REL_NEAR  = 3'd3,
        REL_FAR   = 3'd4
    } relation_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_HALF_X   = 3'd3,
        CFG_HALF_Y   = 3'd4,
        CFG_HALF_Z   = 3'd5,
        CFG_STUCK    = 3'd6,
        CFG_FAR      = 3'd7
    } cfg_addr_t;

endpackage

// ----- sv/brc_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the box relation classifier: object in, relation out, config.
// Depends on brc_pkg.
interface brc_obj_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] obj_center_x;
    logic signed [COORD_WIDTH-1:0] obj_center_y;
    logic signed [COORD_WIDTH-1:0] obj_center_z;
    logic        [COORD_WIDTH-2:0] obj_half_x;
    logic        [COORD_WIDTH-2:0] obj_half_y;
    logic        [COORD_WIDTH-2:0] obj_half_z;

    modport source (
        output valid, obj_center_x, obj_center_y, obj_center_z,
               obj_half_x, obj_half_y, obj_half_z,
        input  ready
    );
    modport sink (
        input  valid, obj_center_x, obj_center_y, obj_center_z,
               obj_half_x, obj_half_y, obj_half_z,
        output ready
    );
endinterface

interface brc_rel_if;
    logic               valid;
    logic               ready;
    brc_pkg::relation_t relation;

    modport source (output valid, relation, input ready);
    modport sink   (input valid, relation, output ready);
endinterface

interface brc_cfg_if #(
    parameter int COORD_WIDTH = 24
);
    logic                   valid;
    logic                   ready;
    brc_pkg::cfg_addr_t     addr;
    logic [COORD_WIDTH-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ----- sv/box_relation_classifier.sv -----
`timescale 1ns / 1ps
// Box relation classifier: classifies an object box against a reference box.
// Depends on brc_pkg and the channel interfaces in brc_if.sv.
//
// Usage:
//   cfg : register writes (addr = register index, data = value). Always ready.
//         Write registers only while no item is in flight; the block does not enforce this.
//   obj : one item per box, centre and half extents per axis.
//   rel : one relation per item, in order: 0 includes, 1 intersects,
//         2 stuck, 3 near, 4 far.
// Timing:
//   Four register stages (input, intervals, gaps/flags, result). A result is
//   valid once its item has moved through each of them. One item per cycle is
//   taken as long as rel drains; each stage holds its item only while the
//   stage after it is full, so bubbles are squeezed out on a stall.
// Reset:
//   All stages empty, centres and halves 0, stuck limit 0.5, far limit 15.
// Stall:
//   While rel is not taken the result is held; up to four items are held in
//   the pipeline before obj.ready drops.
module box_relation_classifier #(
    parameter int COORD_WIDTH = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    brc_obj_if.sink   obj,
    brc_cfg_if.sink   cfg,
    brc_rel_if.source rel
);
    import brc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int HW = COORD_WIDTH - 1;
    localparam int EW = COORD_WIDTH + 2;
    localparam int DW = COORD_WIDTH + 3;
    localparam int GW = COORD_WIDTH + 2;

    // configuration
    logic signed [CW-1:0] ref_c_reg [AXES];
    logic        [HW-1:0] ref_h_reg [AXES];
    logic        [HW-1:0] stuck_reg;
    logic        [HW-1:0] far_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                ref_c_reg[i] <= '0;
                ref_h_reg[i] <= '0;
            end
            stuck_reg <= HW'(STUCK_RESET);
            far_reg   <= HW'(FAR_RESET);
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_CENTER_X: ref_c_reg[0] <= cfg.data;
                CFG_CENTER_Y: ref_c_reg[1] <= cfg.data;
                CFG_CENTER_Z: ref_c_reg[2] <= cfg.data;
                CFG_HALF_X:   ref_h_reg[0] <= cfg.data[HW-1:0];
                CFG_HALF_Y:   ref_h_reg[1] <= cfg.data[HW-1:0];
                CFG_HALF_Z:   ref_h_reg[2] <= cfg.data[HW-1:0];
                CFG_STUCK:    stuck_reg    <= cfg.data[HW-1:0];
                CFG_FAR:      far_reg      <= cfg.data[HW-1:0];
                default:      ;
            endcase
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic free1, free2, free3, free_o;

    assign free_o    = !vo_reg || rel.ready;
    assign free3     = !v3_reg || free_o;
    assign free2     = !v2_reg || free3;
    assign free1     = !v1_reg || free2;
    assign obj.ready = free1;
    assign rel.valid = vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (free1)
                v1_reg <= obj.valid;
            if (free2)
                v2_reg <= v1_reg;
            if (free3)
                v3_reg <= v2_reg;
            if (free_o)
                vo_reg <= v3_reg;
        end
    end

    // stage 1: input register
    logic signed [CW-1:0] s1_c_reg [AXES];
    logic        [HW-1:0] s1_h_reg [AXES];

    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            s1_c_reg[0] <= obj.obj_center_x;
            s1_c_reg[1] <= obj.obj_center_y;
            s1_c_reg[2] <= obj.obj_center_z;
            s1_h_reg[0] <= obj.obj_half_x;
            s1_h_reg[1] <= obj.obj_half_y;
            s1_h_reg[2] <= obj.obj_half_z;
        end
    end

    // per-axis datapath (1 = object, 2 = reference)
    logic signed [EW-1:0] lo1_reg [AXES];
    logic signed [EW-1:0] hi1_reg [AXES];
    logic signed [EW-1:0] lo2_reg [AXES];
    logic signed [EW-1:0] hi2_reg [AXES];
    logic        [GW-1:0] g1_reg  [AXES];
    logic        [GW-1:0] g2_reg  [AXES];
    logic                 starts_in_reg [AXES];
    logic                 incl_reg      [AXES];
    logic [AXES-1:0]      ax_incl, ax_far, ax_near, ax_stuck;
    logic        [GW-1:0] stuck_ext, far_ext;

    assign stuck_ext = GW'(stuck_reg);
    assign far_ext   = GW'(far_reg);

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        logic signed [EW-1:0] oc, oh, rc, rh;
        logic signed [DW-1:0] d1a, d1b, d2a, d2b;
        logic                 swap, starts_in, incl;
        logic                 stuck, far;

        // intervals
        assign oc = EW'(s1_c_reg[a]);
        assign oh = signed'(EW'(s1_h_reg[a]));
        assign rc = EW'(ref_c_reg[a]);
        assign rh = signed'(EW'(ref_h_reg[a]));

        always_ff @(posedge clk)
        begin
            if (free2)
            begin
                lo1_reg[a] <= oc - oh;
                hi1_reg[a] <= oc + oh;
                lo2_reg[a] <= rc - rh;
                hi2_reg[a] <= rc + rh;
            end
        end

        // gaps, both signs in parallel; ordering flags without a swap mux
        assign d1a = DW'(hi2_reg[a]) - DW'(lo1_reg[a]);
        assign d1b = DW'(lo1_reg[a]) - DW'(hi2_reg[a]);
        assign d2a = DW'(lo2_reg[a]) - DW'(hi1_reg[a]);
        assign d2b = DW'(hi1_reg[a]) - DW'(lo2_reg[a]);

        assign swap      = lo2_reg[a] < lo1_reg[a];
        assign starts_in = swap ? (lo1_reg[a] < hi2_reg[a])
                                : ((lo1_reg[a] < lo2_reg[a]) && (lo2_reg[a] < hi1_reg[a]));
        assign incl      = swap ? (hi1_reg[a] < hi2_reg[a]) : (hi2_reg[a] < hi1_reg[a]);

        always_ff @(posedge clk)
        begin
            if (free3)
            begin
                g1_reg[a]        <= d1a[DW-1] ? d1b[GW-1:0] : d1a[GW-1:0];
                g2_reg[a]        <= d2a[DW-1] ? d2b[GW-1:0] : d2a[GW-1:0];
                starts_in_reg[a] <= starts_in;
                incl_reg[a]      <= incl;
            end
        end

        // min(g1, g2) against the limits, taken apart into two compares each
        assign stuck = (g1_reg[a] < stuck_ext) || (g2_reg[a] < stuck_ext);
        assign far   = (g1_reg[a] > far_ext) && (g2_reg[a] > far_ext);

        assign ax_incl[a]  = starts_in_reg[a] && incl_reg[a];
        assign ax_stuck[a] = !starts_in_reg[a] && stuck;
        assign ax_far[a]   = !starts_in_reg[a] && !stuck && far;
        assign ax_near[a]  = !starts_in_reg[a] && !stuck && !far;
    end

    // result
    relation_t rel_next, rel_reg;

    always_comb
    begin
        if (&ax_incl)
            rel_next = REL_INCL;
        else if (|ax_far)
            rel_next = REL_FAR;
        else if (|ax_near)
            rel_next = REL_NEAR;
        else if (|ax_stuck)
            rel_next = REL_STUCK;
        else
            rel_next = REL_INTER;
    end

    always_ff @(posedge clk)
    begin
        if (free_o)
            rel_reg <= rel_next;
    end

    assign rel.relation = rel_reg;

    // checks
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        obj.valid && obj.ready |=> v1_reg)
        else $error("accepted item not captured in stage 1");

    a_stage3_held: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !free_o |=> v3_reg)
        else $error("stage 3 item dropped while output stalled");

    a_all_incl: assert property (@(posedge clk) disable iff (!rst_n)
        free_o && v3_reg && (&ax_incl) |=> rel_reg == REL_INCL)
        else $error("all axes include but result is not includes");

    a_far_wins: assert property (@(posedge clk) disable iff (!rst_n)
        free_o && v3_reg && !(&ax_incl) && (|ax_far) |=> rel_reg == REL_FAR)
        else $error("far axis present but result is not far");

endmodule
